@@ rtl/core/pfp_pkg.sv @@
// Shared widths, constants and the queue item type for the plane-from-three-points block.
// Every module of the block imports this package; it depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pfp_pkg;

  // Coordinate and normal formats.
  localparam int COORD_WIDTH      = 24;
  localparam int NORMAL_FRAC_BITS = 30;

  // Edge vectors, cross product terms and the cross product magnitude.
  localparam int UW     = COORD_WIDTH + 1;
  localparam int PW     = 2 * UW;
  localparam int NW     = PW + 1;
  localparam int MW     = 2 * COORD_WIDTH + 1;
  localparam int LOW_W  = MW / 2;
  localparam int HIGH_W = MW - LOW_W;

  // Squared length and its root.
  localparam int SQW        = 2 * MW;
  localparam int L2W        = ((SQW + 2 + 1) / 2) * 2;
  localparam int SQRT_STEPS = L2W / 2;
  localparam int SQNW       = L2W + 1;
  localparam int LENW       = SQRT_STEPS;

  // Division and dot product.
  localparam int QB   = NORMAL_FRAC_BITS + 2;
  localparam int DW   = LENW + QB;
  localparam int NVW  = QB;
  localparam int SUMW = NVW + COORD_WIDTH + 2;

  // Result formats.
  localparam int NORMAL_W = 32;
  localparam int DIST_W   = 25;

  // Stream widths.
  localparam int NUM_IN_FIELDS = 9;
  localparam int IN_DATA_W     = ((NUM_IN_FIELDS * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = 3 * NORMAL_W + DIST_W;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Decoupling queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Back pipeline: squares, sqrt steps, setup, divide steps, dot product, output.
  localparam int BACK_STAGES = 3 + SQRT_STEPS + 1 + QB + 5 + 1;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_DEGENERATE_LIMIT = '0;
  localparam logic [31:0] LIMIT_RESET = 32'd7;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic [2:0][MW-1:0]          mag;
    logic [2:0]                  neg;
    logic [2:0][COORD_WIDTH-1:0] pt;
  } pfp_item_t;

endpackage

`default_nettype wire

@@ rtl/core/plane_from_three_points.sv @@
// Plane through three points: unit normal and distance from the origin.
// Input transfer to result shown: 4 front stages, the queue, 3 square stages, 50 root
// steps, 1 setup, 32 divide steps, 6 output stages. Throughput is one item per cycle
// while out_tready is high; root and divide are one step per pipeline stage.
// Synchronous active-low reset empties every pipe; degenerate_limit returns to 7.
// Depends on pfp_pkg, pfp_front, pfp_queue and pfp_back.
`timescale 1ns / 1ps
`default_nettype none

module plane_from_three_points import pfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // normal_x, normal_y, normal_z, distance, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // valid_res
  output logic                  out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [31:0]                 limit_r;
  logic                        reg_hit;
  logic [2:0][COORD_WIDTH-1:0] first, second, third;
  logic                        fr_valid, fr_ready, bk_valid, bk_ready;
  pfp_item_t                   fr_item, bk_item;
  logic [2:0][NORMAL_W-1:0]    normal;
  logic [DIST_W-1:0]           distance;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign reg_hit    = cfg_paddr[CFG_ADDR_W-1:2] == REG_DEGENERATE_LIMIT;
  assign cfg_prdata = reg_hit ? limit_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      limit_r <= cfg_pwdata;
    end
  end

  // Unpack the three points.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      first[i]  = in_tdata[i*COORD_WIDTH +: COORD_WIDTH];
      second[i] = in_tdata[(3+i)*COORD_WIDTH +: COORD_WIDTH];
      third[i]  = in_tdata[(6+i)*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  pfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .first     (first),
    .second    (second),
    .third     (third),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_item  (fr_item)
  );

  pfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_item   (fr_item),
    .out_valid (bk_valid),
    .out_ready (bk_ready),
    .out_item  (bk_item)
  );

  pfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .limit     (limit_r),
    .in_valid  (bk_valid),
    .in_ready  (bk_ready),
    .in_item   (bk_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .normal    (normal),
    .distance  (distance),
    .plane_ok  (out_tuser)
  );

  // Pack the result.
  assign out_tdata = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, distance,
                      normal[2], normal[1], normal[0]};

endmodule

`default_nettype wire

@@ rtl/core/pfp_front.sv @@
// Front part: edge vectors, cross product and its sign/magnitude form.
// Depends on pfp_pkg; the whole four-stage pipe stalls when its output is held.
`timescale 1ns / 1ps
`default_nettype none

module pfp_front import pfp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0][COORD_WIDTH-1:0] first,
  input  logic [2:0][COORD_WIDTH-1:0] second,
  input  logic [2:0][COORD_WIDTH-1:0] third,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pfp_item_t                   out_item
);

  logic                        adv;
  logic [3:0]                  vld_r;
  logic [2:0][COORD_WIDTH-1:0] pt1_r, pt2_r, pt3_r;
  logic signed [UW-1:0]        uvec_r [3];
  logic signed [UW-1:0]        vvec_r [3];
  logic signed [PW-1:0]        prod_r [6];
  logic signed [NW-1:0]        nvec_r [3];
  logic signed [NW-1:0]        nabs   [3];
  pfp_item_t                   item_nxt, item_r;

  // The pipe moves as a whole whenever its last stage is free or drained.
  assign adv       = !vld_r[3] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[3];
  assign out_item  = item_r;

  // Valid bits for the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  // Sign and magnitude of each cross product component.
  always_comb begin
    item_nxt.pt = pt3_r;
    for (int i = 0; i < 3; i++) begin
      nabs[i]          = nvec_r[i][NW-1] ? -nvec_r[i] : nvec_r[i];
      item_nxt.mag[i]  = nabs[i][MW-1:0];
      item_nxt.neg[i]  = nvec_r[i][NW-1];
    end
  end

  // Edge vectors, the six products and the component differences.
  always_ff @(posedge clk) begin
    if (adv) begin
      pt1_r <= first;
      for (int i = 0; i < 3; i++) begin
        uvec_r[i] <= $signed({second[i][COORD_WIDTH-1], second[i]})
                   - $signed({first[i][COORD_WIDTH-1], first[i]});
        vvec_r[i] <= $signed({third[i][COORD_WIDTH-1], third[i]})
                   - $signed({first[i][COORD_WIDTH-1], first[i]});
      end
      pt2_r     <= pt1_r;
      prod_r[0] <= uvec_r[1] * vvec_r[2];
      prod_r[1] <= uvec_r[2] * vvec_r[1];
      prod_r[2] <= uvec_r[2] * vvec_r[0];
      prod_r[3] <= uvec_r[0] * vvec_r[2];
      prod_r[4] <= uvec_r[0] * vvec_r[1];
      prod_r[5] <= uvec_r[1] * vvec_r[0];
      pt3_r     <= pt2_r;
      nvec_r[0] <= NW'(prod_r[0]) - NW'(prod_r[1]);
      nvec_r[1] <= NW'(prod_r[2]) - NW'(prod_r[3]);
      nvec_r[2] <= NW'(prod_r[4]) - NW'(prod_r[5]);
      item_r    <= item_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pfp_queue.sv @@
// Short queue that decouples the front pipe from the back pipe.
// Depends on pfp_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module pfp_queue import pfp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pfp_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output pfp_item_t out_item
);

  pfp_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              push, pop;

  assign in_ready  = count_r != (QPTR_W + 1)'(QDEPTH);
  assign out_valid = count_r != '0;
  assign out_item  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_item;
  end

endmodule

`default_nettype wire

@@ rtl/core/pfp_back.sv @@
// Back part: squared length, pipelined root, pipelined divide and the distance.
// Depends on pfp_pkg; the whole pipe advances when its output is free or taken.
`timescale 1ns / 1ps
`default_nettype none

module pfp_back import pfp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [31:0]              limit,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  pfp_item_t                in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0][NORMAL_W-1:0] normal,
  output logic [DIST_W-1:0]        distance,
  output logic                     plane_ok
);

  logic                   adv;
  logic [BACK_STAGES-1:0] vld_r;

  // Square terms.
  logic [2*HIGH_W-1:0] hh_r [3];
  logic [MW-1:0]       hl_r [3];
  logic [2*LOW_W-1:0]  ll_r [3];
  logic [SQW-1:0]      sq_r [3];
  logic [L2W-1:0]      len2_r;
  pfp_item_t           item_p1_r, item_p2_r, item_p3_r;

  // Root steps.
  logic [SQNW-1:0] sq_num_r [SQRT_STEPS];
  logic [SQNW-1:0] sq_res_r [SQRT_STEPS];
  pfp_item_t       sq_item_r [SQRT_STEPS];

  // Divide setup and steps.
  logic [LENW-1:0]    len_e_r;
  logic               degen_e_r;
  logic [DW-1:0]      dn_e_r [3];
  pfp_item_t          item_e_r;
  logic [DW-1:0]      dv_num_r [QB][3];
  logic [QB-1:0]      dv_q_r   [QB][3];
  logic [LENW-1:0]    dv_len_r [QB];
  logic               dv_degen_r [QB];
  pfp_item_t          dv_item_r [QB];

  // Dot product and rounding.
  logic [2:0][NVW-1:0]        nv_pipe_r [5];
  logic                       degen_pipe_r [5];
  logic [2:0][COORD_WIDTH-1:0] pt_d1_r;
  logic signed [NVW+COORD_WIDTH-1:0] dprod_r [3];
  logic signed [SUMW-1:0]     dsum_r;
  logic [SUMW-1:0]            dmag_r;
  logic [SUMW-1:0]            dround_r;
  logic                       dneg_d4_r, dneg_d5_r;

  // Output register.
  logic [2:0][NORMAL_W-1:0] normal_r, normal_nxt;
  logic [DIST_W-1:0]        dist_r, dist_nxt;
  logic                     ok_r;
  logic [SUMW-1:0]          dround_neg;

  localparam logic [DIST_W-1:0] DIST_MAX_V = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W-1:0] DIST_MIN_V = {1'b1, {(DIST_W-1){1'b0}}};
  localparam logic [SUMW-1:0]   ROUND_HALF = SUMW'(1) << (NORMAL_FRAC_BITS - 1);

  assign adv       = !vld_r[BACK_STAGES-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[BACK_STAGES-1];
  assign normal    = normal_r;
  assign distance  = dist_r;
  assign plane_ok  = ok_r;

  // One valid bit per stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[BACK_STAGES-2:0], in_valid};
    end
  end

  // Squares from split partial products, then their sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      item_p1_r <= in_item;
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= in_item.mag[i][MW-1:LOW_W] * in_item.mag[i][MW-1:LOW_W];
        hl_r[i] <= in_item.mag[i][MW-1:LOW_W] * in_item.mag[i][LOW_W-1:0];
        ll_r[i] <= in_item.mag[i][LOW_W-1:0] * in_item.mag[i][LOW_W-1:0];
      end
      item_p2_r <= item_p1_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= {hh_r[i], ll_r[i]} + (SQW'(hl_r[i]) << (LOW_W + 1));
      end
      item_p3_r <= item_p2_r;
      len2_r    <= L2W'(sq_r[0]) + L2W'(sq_r[1]) + L2W'(sq_r[2]);
    end
  end

  // Bit-by-bit square root, one result bit per stage.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQNW-1:0] SBIT = SQNW'(1) << (L2W - 2 - 2 * k);
    logic [SQNW-1:0] num_in, res_in, trial;
    pfp_item_t       item_in;
    logic            take;

    if (k == 0) begin : g_first
      assign num_in  = SQNW'(len2_r);
      assign res_in  = '0;
      assign item_in = item_p3_r;
    end else begin : g_next
      assign num_in  = sq_num_r[k-1];
      assign res_in  = sq_res_r[k-1];
      assign item_in = sq_item_r[k-1];
    end

    assign trial = res_in + SBIT;
    assign take  = num_in >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_num_r[k]  <= take ? num_in - trial : num_in;
        sq_res_r[k]  <= take ? (res_in >> 1) + SBIT : res_in >> 1;
        sq_item_r[k] <= item_in;
      end
    end
  end

  // Degenerate test and rounded dividends.
  always_ff @(posedge clk) begin
    if (adv) begin
      len_e_r   <= sq_res_r[SQRT_STEPS-1][LENW-1:0];
      degen_e_r <= sq_res_r[SQRT_STEPS-1][LENW-1:0] <= LENW'(limit);
      item_e_r  <= sq_item_r[SQRT_STEPS-1];
      for (int i = 0; i < 3; i++) begin
        dn_e_r[i] <= (DW'(sq_item_r[SQRT_STEPS-1].mag[i]) << NORMAL_FRAC_BITS)
                   + DW'(sq_res_r[SQRT_STEPS-1][LENW-1:0] >> 1);
      end
    end
  end

  // Restoring divide, one quotient bit per stage in each of three lanes.
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int SH = QB - 1 - j;
    logic [DW-1:0]   num_in [3];
    logic [QB-1:0]   q_in   [3];
    logic [LENW-1:0] len_in;
    logic            degen_in;
    pfp_item_t       item_in;
    logic [DW-1:0]   dsh;

    if (j == 0) begin : g_first
      assign num_in   = dn_e_r;
      assign q_in     = '{default: '0};
      assign len_in   = len_e_r;
      assign degen_in = degen_e_r;
      assign item_in  = item_e_r;
    end else begin : g_next
      assign num_in   = dv_num_r[j-1];
      assign q_in     = dv_q_r[j-1];
      assign len_in   = dv_len_r[j-1];
      assign degen_in = dv_degen_r[j-1];
      assign item_in  = dv_item_r[j-1];
    end

    assign dsh = DW'(len_in) << SH;

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          dv_num_r[j][i] <= (num_in[i] >= dsh) ? num_in[i] - dsh : num_in[i];
          dv_q_r[j][i]   <= {q_in[i][QB-2:0], num_in[i] >= dsh};
        end
        dv_len_r[j]   <= len_in;
        dv_degen_r[j] <= degen_in;
        dv_item_r[j]  <= item_in;
      end
    end
  end

  // Signed normal, products with the first point, sum, magnitude and rounding.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        nv_pipe_r[0][i] <= dv_item_r[QB-1].neg[i] ? -dv_q_r[QB-1][i] : dv_q_r[QB-1][i];
      end
      degen_pipe_r[0] <= dv_degen_r[QB-1];
      pt_d1_r         <= dv_item_r[QB-1].pt;
      for (int s = 1; s < 5; s++) begin
        nv_pipe_r[s]    <= nv_pipe_r[s-1];
        degen_pipe_r[s] <= degen_pipe_r[s-1];
      end
      for (int i = 0; i < 3; i++) begin
        dprod_r[i] <= $signed(nv_pipe_r[0][i]) * $signed(pt_d1_r[i]);
      end
      dsum_r    <= SUMW'(dprod_r[0]) + SUMW'(dprod_r[1]) + SUMW'(dprod_r[2]);
      dmag_r    <= dsum_r[SUMW-1] ? -dsum_r : dsum_r;
      dneg_d4_r <= dsum_r[SUMW-1];
      dround_r  <= (dmag_r + ROUND_HALF) >> NORMAL_FRAC_BITS;
      dneg_d5_r <= dneg_d4_r;
    end
  end

  // Saturation and the zeroing of degenerate planes.
  always_comb begin
    dround_neg = -dround_r;
    if (dneg_d5_r) begin
      dist_nxt = (dround_r > SUMW'(DIST_MIN_V)) ? DIST_MIN_V : dround_neg[DIST_W-1:0];
    end else begin
      dist_nxt = (dround_r > SUMW'(DIST_MAX_V)) ? DIST_MAX_V : dround_r[DIST_W-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      normal_nxt[i] = NORMAL_W'($signed(nv_pipe_r[4][i]));
    end
    if (degen_pipe_r[4]) begin
      dist_nxt   = '0;
      normal_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      normal_r <= normal_nxt;
      dist_r   <= dist_nxt;
      ok_r     <= !degen_pipe_r[4];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pfp_checker.sv @@
// Port-level checks for plane_from_three_points, bound to the top level.
// Depends on pfp_pkg for the port widths.
`timescale 1ns / 1ps
`default_nettype none

module pfp_checker import pfp_pkg::*; (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  out_tvalid,
  input wire                  out_tready,
  input wire [OUT_DATA_W-1:0] out_tdata,
  input wire                  out_tuser
);

  // A held result transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // A degenerate plane carries all-zero fields.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("degenerate plane with nonzero fields");

  // Each normal component of a valid plane stays within plus or minus one.
  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      ($signed(out_tdata[31:0])  <= 32'sh4000_0000) &&
      ($signed(out_tdata[31:0])  >= -32'sh4000_0000) &&
      ($signed(out_tdata[63:32]) <= 32'sh4000_0000) &&
      ($signed(out_tdata[63:32]) >= -32'sh4000_0000) &&
      ($signed(out_tdata[95:64]) <= 32'sh4000_0000) &&
      ($signed(out_tdata[95:64]) >= -32'sh4000_0000))
    else $error("normal component out of range");

endmodule

bind plane_from_three_points pfp_checker u_pfp_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for plane_from_three_points: streams point triples, predicts each plane.
// Depends on pfp_pkg and the plane_from_three_points RTL.
`timescale 1ns / 1ps

module testbench;
  import pfp_pkg::*;

  // Expected plane for one point triple.
  typedef struct {
    logic [31:0] nx, ny, nz;
    logic [24:0] distance;
    logic        ok;
  } plane_t;

  // Plane predictor and in-order store of expected planes.
  class plane_board;
    plane_t      planes_due[$];
    logic [31:0] limit;
    int          errors;

    function new();
      limit  = LIMIT_RESET;
      errors = 0;
    endfunction

    // Work out the plane for an accepted triple and queue it.
    function void note_triple(logic [IN_DATA_W-1:0] d);
      longint      pa[3], eu[3], ev[3], cr[3], nv[3], sum, rnd;
      logic [127:0] mag[3], l2, rem, root, bitv, trial, num, q;
      plane_t      p;
      for (int i = 0; i < 3; i++) begin
        pa[i] = longint'($signed(d[i*COORD_WIDTH +: COORD_WIDTH]));
        eu[i] = longint'($signed(d[(3+i)*COORD_WIDTH +: COORD_WIDTH])) - pa[i];
        ev[i] = longint'($signed(d[(6+i)*COORD_WIDTH +: COORD_WIDTH])) - pa[i];
      end
      // Exact cross product of the edge vectors.
      cr[0] = eu[1] * ev[2] - eu[2] * ev[1];
      cr[1] = eu[2] * ev[0] - eu[0] * ev[2];
      cr[2] = eu[0] * ev[1] - eu[1] * ev[0];
      l2 = '0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = 128'(cr[i] < 0 ? -cr[i] : cr[i]);
        l2 += mag[i] * mag[i];
      end
      // Floor square root, one result bit per step.
      rem  = l2;
      root = '0;
      bitv = 128'd1 << 126;
      while (bitv != 0) begin
        trial = root + bitv;
        if (rem >= trial) begin
          rem  = rem - trial;
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      p = '{default: '0};
      if (root > 128'(limit)) begin
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          num   = (mag[i] << NORMAL_FRAC_BITS) + (root >> 1);
          q     = num / root;
          nv[i] = cr[i] < 0 ? -longint'(q) : longint'(q);
          sum  += nv[i] * pa[i];
        end
        rnd = ((sum < 0 ? -sum : sum) + (64'sd1 <<< (NORMAL_FRAC_BITS - 1)))
              >>> NORMAL_FRAC_BITS;
        if (sum < 0) rnd = -rnd;
        if (rnd > 16777215) rnd = 16777215;
        if (rnd < -16777216) rnd = -16777216;
        p.nx       = nv[0][31:0];
        p.ny       = nv[1][31:0];
        p.nz       = nv[2][31:0];
        p.distance = rnd[24:0];
        p.ok       = 1'b1;
      end
      planes_due = {planes_due, p};
    endfunction

    // Compare one accepted result with the oldest expected plane.
    function void check_plane(logic [OUT_DATA_W-1:0] d, logic u);
      plane_t p;
      if (planes_due.size() == 0) begin
        $error("unexpected result transfer: data %h user %b", d, u);
        errors++;
        return;
      end
      p = planes_due.pop_front();
      if (d[31:0] !== p.nx) begin
        $error("normal_x expected %h actual %h", p.nx, d[31:0]); errors++;
      end
      if (d[63:32] !== p.ny) begin
        $error("normal_y expected %h actual %h", p.ny, d[63:32]); errors++;
      end
      if (d[95:64] !== p.nz) begin
        $error("normal_z expected %h actual %h", p.nz, d[95:64]); errors++;
      end
      if (d[120:96] !== p.distance) begin
        $error("distance expected %h actual %h", p.distance, d[120:96]); errors++;
      end
      if (u !== p.ok) begin
        $error("valid_res expected %b actual %b", p.ok, u); errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  plane_board board = new();
  bit         calm = 1'b0;
  longint     cycles = 0;
  int         stall_left = 0;

  plane_from_three_points dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Note every accepted triple and check every accepted result.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_triple(in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_plane(out_tdata, out_tuser);
  end

  // Result side backpressure in random bursts.
  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Register write: setup phase, then access phase, then idle.
  task automatic reg_write(logic [CFG_ADDR_W-1:0] addr, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == {REG_DEGENERATE_LIMIT, 2'b00}) board.limit = value;
    @(posedge clk);
  endtask

  // Register read, checked against the value the predictor holds.
  task automatic limit_readback();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {REG_DEGENERATE_LIMIT, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== board.limit) begin
      $error("degenerate_limit expected %h actual %h", board.limit, cfg_prdata);
      board.errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one triple and hold it until the transfer happens.
  task automatic send_triple(int pts[9]);
    logic [IN_DATA_W-1:0] d;
    int                   gap;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*COORD_WIDTH +: COORD_WIDTH] = pts[i][COORD_WIDTH-1:0];
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random triple: full range, small, near-collinear or repeated points.
  task automatic random_triple(output int pts[9]);
    int kind, k;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (kind < 3) pts[i] = $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
      else pts[i] = $urandom_range(0, 4096) - 2048;
    end
    if (kind == 7 || kind == 8) begin
      k = $urandom_range(0, 6) - 3;
      for (int i = 0; i < 3; i++)
        pts[6+i] = pts[i] + k * (pts[3+i] - pts[i]) + $urandom_range(0, 2) - 1;
    end else if (kind == 9) begin
      for (int i = 0; i < 3; i++) pts[3+i] = pts[i];
    end
  endtask

  task automatic drain();
    while (board.planes_due.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  int dir [20][9];
  int pts[9];

  initial begin
    int mx, mn;
    mx = 8388607;
    mn = -8388608;
    dir[0]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    dir[1]  = '{mx, mx, mx, mx, mx, mx, mx, mx, mx};
    dir[2]  = '{mn, mn, mn, mn, mn, mn, mn, mn, mn};
    dir[3]  = '{mx, mx, mx, mn, mx, mx, mx, mn, mx};
    dir[4]  = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};
    dir[5]  = '{mx, mn, mx, mn, mx, mn, mx, mx, mn};
    dir[6]  = '{mn, mx, mn, mx, mn, mx, mn, mn, mx};
    dir[7]  = '{0, 0, mx, mx, 0, mx, 0, mx, mx};
    dir[8]  = '{0, 0, mn, mn, 0, mn, 0, mn, mn};
    dir[9]  = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
    dir[10] = '{0, 0, 0, 0, 256, 0, 256, 0, 0};
    dir[11] = '{100, 200, 300, 200, 400, 600, 300, 600, 900};
    dir[12] = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    dir[13] = '{0, 0, 0, 7, 0, 0, 0, 1, 0};
    dir[14] = '{0, 0, 0, 8, 0, 0, 0, 1, 0};
    dir[15] = '{0, 0, 0, 3, 0, 0, 0, 3, 0};
    dir[16] = '{mx, 0, 0, mx, 256, 0, mx, 0, 256};
    dir[17] = '{mn, mn, mn, mn, mn + 256, mn, mn, mn, mn + 256};
    dir[18] = '{-5, 7, -9, 11, -13, 17, -19, 23, -29};
    dir[19] = '{5, 5, 5, 5, 5, 5, 9, 9, 9};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limit, directed triples, then random.
    limit_readback();
    foreach (dir[i]) send_triple(dir[i]);
    for (int n = 0; n < 110; n++) begin random_triple(pts); send_triple(pts); end
    in_tvalid <= 1'b0;
    drain();

    // Zero limit: only a zero length is degenerate.
    reg_write({REG_DEGENERATE_LIMIT, 2'b00}, 32'd0);
    reg_write(3'd4, 32'h1234_5678);
    limit_readback();
    foreach (dir[i]) send_triple(dir[i]);
    for (int n = 0; n < 100; n++) begin random_triple(pts); send_triple(pts); end
    in_tvalid <= 1'b0;
    drain();

    // Largest limit: every plane from the small point sets is degenerate.
    reg_write({REG_DEGENERATE_LIMIT, 2'b00}, 32'hFFFF_FFFF);
    limit_readback();
    for (int n = 0; n < 60; n++) begin random_triple(pts); send_triple(pts); end
    in_tvalid <= 1'b0;
    drain();

    // Random limits across the range.
    for (int ph = 0; ph < 2; ph++) begin
      reg_write({REG_DEGENERATE_LIMIT, 2'b00}, $urandom() >> $urandom_range(0, 31));
      for (int n = 0; n < 90; n++) begin random_triple(pts); send_triple(pts); end
      in_tvalid <= 1'b0;
      drain();
    end

    // Back to the reset value, full rate on both sides.
    reg_write({REG_DEGENERATE_LIMIT, 2'b00}, LIMIT_RESET);
    calm = 1'b1;
    for (int n = 0; n < 80; n++) begin random_triple(pts); send_triple(pts); end
    in_tvalid <= 1'b0;
    drain();

    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
